// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared entry, control and code definitions for the queue core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int ValueW = 32;
  localparam int PriW   = 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_EVICT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_POP    = 2'd1,
    CELL_INSERT = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
    logic [PriW-1:0]   pri;
  } entry_t;

  typedef struct packed {
    cell_op_t          op;
    logic              evict;
    logic [ValueW-1:0] value;
    logic [PriW-1:0]   pri;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one queue entry and shifts, keeps or loads it using its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire spq_pkg::entry_t    left,
  input  wire spq_pkg::entry_t    right,
  input  wire logic               left_keep,
  output spq_pkg::entry_t         entry,
  output spq_pkg::entry_t         entry_next,
  output logic                    keep
);

  spq_pkg::entry_t view;
  spq_pkg::entry_t view_left;
  spq_pkg::entry_t new_entry;

  // On an evicting insert the row is seen as already shifted toward the head.
  always_comb begin
    view          = ctrl.evict ? right : entry;
    view_left     = ctrl.evict ? entry : left;
    new_entry     = '{valid: 1'b1, value: ctrl.value, pri: ctrl.pri};
    keep          = view.valid && (view.pri >= ctrl.pri);
  end

  always_comb begin
    case (ctrl.op)
      spq_pkg::CELL_POP: begin
        entry_next = right;
      end
      spq_pkg::CELL_INSERT: begin
        if (keep) begin
          entry_next = view;
        end else if (left_keep) begin
          entry_next = new_entry;
        end else begin
          entry_next = view_left;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.value <= entry_next.value;
    entry.pri   <= entry_next.pri;
  end

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Bounded queue of value/priority entries kept sorted in a row of cells.
// ----------------------------------------------------------------------------
// An accepted request's result is written into the output register in the next cycle.
// Throughput: one request per cycle while the output register is free; every cell decides from its neighbors.
// A new request is taken while the output register is empty or being drained.
// Reset is synchronous and empties the queue and the output register.
`default_nettype none

module sorted_priority_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // item_value[31:0], item_priority[39:32]
  input  wire logic        s_tuser,   // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // out_value[31:0], entry_count[36:32],
                                      // head_value[68:37], zero fill[71:69]
  output logic [1:0]       m_tuser    // status
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  spq_pkg::entry_t    cell_q    [QUEUE_DEPTH];
  spq_pkg::entry_t    cell_d    [QUEUE_DEPTH];
  logic               cell_keep [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_vec;
  spq_pkg::cell_ctrl_t ctrl;

  logic              accept;
  logic              full;
  logic              empty;
  logic              take_head;
  logic [CntW-1:0]   count;
  logic [CntW-1:0]   count_next;
  logic [CntW+4:0]   count_ext;
  logic [31:0]       res_value;
  logic [31:0]       res_head;
  spq_pkg::status_t  res_status;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = cell_q[QUEUE_DEPTH-1].valid;
  assign empty    = !cell_q[0].valid;

  always_comb begin
    ctrl.value = s_tdata[31:0];
    ctrl.pri   = s_tdata[39:32];
    ctrl.evict = 1'b0;
    ctrl.op    = spq_pkg::CELL_HOLD;
    take_head  = 1'b0;
    res_status = spq_pkg::ST_OK;
    count_next = count;
    if (accept) begin
      if (spq_pkg::opcode_t'(s_tuser) == spq_pkg::OP_INSERT) begin
        ctrl.op    = spq_pkg::CELL_INSERT;
        ctrl.evict = full;
        take_head  = full;
        if (full) begin
          res_status = spq_pkg::ST_EVICT;
        end else begin
          count_next = CntW'(count + 1'b1);
        end
      end else if (empty) begin
        res_status = spq_pkg::ST_EMPTY;
      end else begin
        ctrl.op    = spq_pkg::CELL_POP;
        take_head  = 1'b1;
        count_next = CntW'(count - 1'b1);
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left;
    spq_pkg::entry_t right;
    logic            left_keep;

    if (i == 0) begin : g_first
      assign left      = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left      = cell_q[i-1];
      assign left_keep = cell_keep[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left       (left),
      .right      (right),
      .left_keep  (left_keep),
      .entry      (cell_q[i]),
      .entry_next (cell_d[i]),
      .keep       (cell_keep[i])
    );

    assign valid_vec[i] = cell_q[i].valid;
  end

  assign res_value = take_head ? cell_q[0].value : '0;
  assign res_head  = cell_d[0].valid ? cell_d[0].value : '0;
  assign count_ext = {5'b0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (accept) begin
      m_tdata <= {3'b0, res_head, count_ext[4:0], res_value};
      m_tuser <= res_status;
    end
  end

  a_valid_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("queue cells are not filled from the head");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("entry count disagrees with occupied cells");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == spq_pkg::ST_EMPTY) |-> (m_tdata[31:0] == '0))
    else $error("remove on empty queue returned a value");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    accept && (s_tuser == spq_pkg::OP_INSERT) && full |=> full)
    else $error("evicting insert changed the queue fill");

endmodule

`default_nettype wire
